@@ design/tws_pkg.sv @@
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants for the threshold window zero suppressor.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int SAMPLE_W  = 15;
    localparam int WORD_W    = 16;
    localparam int OFFSET_W  = 14;
    localparam int RUN_W     = 15;
    localparam int CFG_IDX_W = 1;

    localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RESET  = 15'd65;
    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RESET = 15'd959;
    localparam logic [RUN_W-1:0]    RUN_SATURATE         = 15'h7fff;
    localparam logic                SKIP_MARK            = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                record_start;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [OFFSET_W-1:0] trigger_offset;
        logic                last_of_item;
    } out_word_t;

    // one kept sample, with the skip word that precedes it if any
    typedef struct packed {
        logic                has_skip;
        logic [OFFSET_W-1:0] skip_len;
        logic [SAMPLE_W-1:0] sample;
        logic [OFFSET_W-1:0] offset;
    } cmd_t;

endpackage

@@ design/tws_stream_if.sv @@
// ----------------------------------------------------------------------------
// tws_stream_if
// Valid/ready stream carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface tws_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/threshold_window_zero_suppressor.sv @@
// ----------------------------------------------------------------------------
// threshold_window_zero_suppressor
// Zero suppression of a sample stream against a threshold window.
//
//   channel   dir   width  handshake     contents
//   samples   in    16     valid/ready   sample, record_start
//   results   out   31     valid/ready   word, trigger_offset, last_of_item
//   cfg       in    16     write enable  cfg_index, cfg_data
//
// One sample is accepted per cycle while the command queue has room. A kept
// sample gives one output word, or two when a skip run precedes it; the
// output register sends one word per cycle while results is ready, so the
// back end sets the rate. Results pass through the queue and output register.
// Reset loads the default thresholds and clears record state and the queue.
// Either side may stall; the queue decouples them.
// ----------------------------------------------------------------------------
module threshold_window_zero_suppressor #(
    parameter int RECORD_MAX = 16384
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tws_stream_if.sink                    samples,
    tws_stream_if.source                  results,
    input  logic                          cfg_we,
    input  logic [tws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tws_pkg::SAMPLE_W-1:0]  cfg_data
);

    logic          push_valid, push_ready, pop_valid, pop;
    tws_pkg::cmd_t push_cmd, pop_cmd;

    tws_front #(
        .RECORD_MAX (RECORD_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (samples.valid),
        .in_ready   (samples.ready),
        .in_payload (samples.payload),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    tws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    tws_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (pop_valid),
        .cmd         (pop_cmd),
        .cmd_pop     (pop),
        .out_valid   (results.valid),
        .out_ready   (results.ready),
        .out_payload (results.payload)
    );

endmodule

@@ design/tws_front.sv @@
// ----------------------------------------------------------------------------
// tws_front
// Holds thresholds and record state, classifies each sample and queues
// kept samples together with any pending skip run.
// ----------------------------------------------------------------------------
module tws_front #(
    parameter int RECORD_MAX = 16384
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tws_pkg::in_word_t              in_payload,
    input  logic                           cfg_we,
    input  logic [tws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tws_pkg::SAMPLE_W-1:0]   cfg_data,
    output logic                           push_valid,
    input  logic                           push_ready,
    output tws_pkg::cmd_t                  push_cmd
);

    localparam int PW = $clog2(RECORD_MAX);
    localparam logic [PW-1:0] POS_LAST = PW'(RECORD_MAX - 1);

    logic [tws_pkg::SAMPLE_W-1:0] low_reg, high_reg;
    logic                         triggered_reg, triggered_next;
    logic [tws_pkg::RUN_W-1:0]    run_reg, run_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic [PW-1:0]                fkp_reg, fkp_next;

    logic                         accept, kept, trig_cur;
    logic [tws_pkg::RUN_W-1:0]    run_cur, run_less;
    logic [PW-1:0]                here, fkp_sel;
    logic [PW+tws_pkg::OFFSET_W-1:0] fkp_ext;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        trig_cur = in_payload.record_start ? 1'b0 : triggered_reg;
        run_cur  = in_payload.record_start ? '0 : run_reg;
        here     = in_payload.record_start ? '0 : pos_reg;
        kept     = (in_payload.sample < low_reg) || (in_payload.sample > high_reg);
        run_less = run_cur - tws_pkg::RUN_W'(1);
        fkp_sel  = trig_cur ? fkp_reg : here;
        fkp_ext  = {{tws_pkg::OFFSET_W{1'b0}}, fkp_sel};

        pos_next       = (here == POS_LAST) ? '0 : here + PW'(1);
        triggered_next = trig_cur;
        fkp_next       = fkp_reg;
        run_next       = run_cur;
        if (kept)
        begin
            triggered_next = 1'b1;
            fkp_next       = fkp_sel;
            run_next       = '0;
        end
        else if (trig_cur && (run_cur != tws_pkg::RUN_SATURATE))
        begin
            run_next = run_cur + tws_pkg::RUN_W'(1);
        end

        push_valid        = in_valid && kept;
        push_cmd.has_skip = (run_cur != '0);
        push_cmd.skip_len = run_less[tws_pkg::OFFSET_W-1:0];
        push_cmd.sample   = in_payload.sample;
        push_cmd.offset   = fkp_ext[tws_pkg::OFFSET_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= tws_pkg::LOW_THRESHOLD_RESET;
            high_reg      <= tws_pkg::HIGH_THRESHOLD_RESET;
            triggered_reg <= 1'b0;
            run_reg       <= '0;
            pos_reg       <= '0;
            fkp_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tws_pkg::REG_LOW_THRESHOLD:  low_reg  <= cfg_data;
                    tws_pkg::REG_HIGH_THRESHOLD: high_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                triggered_reg <= triggered_next;
                run_reg       <= run_next;
                pos_reg       <= pos_next;
                fkp_reg       <= fkp_next;
            end
        end
    end

endmodule

@@ design/tws_queue.sv @@
// ----------------------------------------------------------------------------
// tws_queue
// Short FIFO of kept-sample commands between the front and back ends.
// ----------------------------------------------------------------------------
module tws_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tws_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output tws_pkg::cmd_t pop_cmd
);

    localparam int CW = tws_pkg::QUEUE_PTR_W + 1;

    tws_pkg::cmd_t                  mem_reg [tws_pkg::QUEUE_DEPTH];
    logic [tws_pkg::QUEUE_PTR_W-1:0] wr_reg, rd_reg;
    logic [CW-1:0]                  count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = (count_reg != CW'(tws_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_reg <= wr_reg + tws_pkg::QUEUE_PTR_W'(1);
            if (do_pop)
                rd_reg <= rd_reg + tws_pkg::QUEUE_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_cmd;
    end

endmodule

@@ design/tws_back.sv @@
// ----------------------------------------------------------------------------
// tws_back
// Expands queued commands into output words: skip word first, then sample.
// ----------------------------------------------------------------------------
module tws_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  tws_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output tws_pkg::out_word_t out_payload
);

    logic               valid_reg;
    logic               skip_sent_reg, skip_sent_next;
    tws_pkg::out_word_t data_reg, data_next;
    logic               load, emit_skip;

    assign out_valid   = valid_reg;
    assign out_payload = data_reg;
    assign load        = !valid_reg || out_ready;
    assign emit_skip   = cmd.has_skip && !skip_sent_reg;
    assign cmd_pop     = load && cmd_valid && !emit_skip;

    always_comb
    begin
        data_next.trigger_offset = cmd.offset;
        if (emit_skip)
        begin
            data_next.word         = {tws_pkg::SKIP_MARK, 1'b0, cmd.skip_len};
            data_next.last_of_item = 1'b0;
            skip_sent_next         = 1'b1;
        end
        else
        begin
            data_next.word         = {1'b0, cmd.sample};
            data_next.last_of_item = 1'b1;
            skip_sent_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            skip_sent_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= cmd_valid;
            if (cmd_valid)
                skip_sent_reg <= skip_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && cmd_valid)
            data_reg <= data_next;
    end

endmodule

@@ design/tws_checker.sv @@
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks on the output stream of the zero suppressor.
// ----------------------------------------------------------------------------
module tws_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               valid,
    input logic               ready,
    input tws_pkg::out_word_t payload
);

    // a stalled word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
    else $error("output word withdrawn while stalled");

    // a word that is not the last of its item must be a skip word
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !payload.last_of_item |-> payload.word[15])
    else $error("non-final word without skip marker");

    // a kept sample never carries the skip marker
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && payload.last_of_item |-> !payload.word[15])
    else $error("final word carries skip marker");

    // skip word is followed at once by its sample, same trigger offset
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !payload.last_of_item |=>
            valid && payload.last_of_item &&
            (payload.trigger_offset == $past(payload.trigger_offset)))
    else $error("skip word not followed by its sample");

endmodule

bind threshold_window_zero_suppressor tws_checker u_tws_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid   (results.valid),
    .ready   (results.ready),
    .payload (results.payload)
);
